/* hdl/sine_cosine_polynomial_assert.svh */
// Assertion macros for the sine / cosine polynomial block
`ifndef SINE_COSINE_POLYNOMIAL_ASSERT_SVH
`define SINE_COSINE_POLYNOMIAL_ASSERT_SVH

// Check cons at every edge at which ante holds, outside reset
`define SCP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cond at every edge, outside reset
`define SCP_ASSERT_HOLD(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

/* hdl/scp_pkg.sv */
// Shared types, constants and coefficient tables of the sine / cosine polynomial block
package scp_pkg;

  localparam logic [63:0]  PI58      = 64'd905502432259640358;
  localparam logic [63:0]  HALF58    = 64'd452751216129820179;
  localparam logic [63:0]  TAU58     = 64'd1811004864519280716;
  localparam logic [31:0]  INV_TAU32 = 32'd683565275;
  localparam logic [63:0]  ONE60     = 64'd1152921504606846976;
  localparam logic [127:0] ROUND60   = 128'd576460752303423488;
  localparam logic [63:0]  ROUND30   = 64'd536870912;
  localparam logic [30:0]  SAT30     = 31'd1073741824;

  localparam int RED_STAGES = 7;
  localparam int MAC_STAGES = 5;
  localparam int NUM_MAC    = 9;

  typedef logic [3:0] step_t;

  typedef struct packed {
    logic        is_sin;
    logic        neg;
    logic [63:0] x60;
    logic [63:0] y;
  } side_t;

  // q times 2*pi in Q.58
  function automatic logic [63:0] tau_mult(input logic [2:0] q);
    logic [63:0] t;
    case (q)
      3'd0:    t = '0;
      3'd1:    t = TAU58;
      3'd2:    t = TAU58 * 64'd2;
      3'd3:    t = TAU58 * 64'd3;
      3'd4:    t = TAU58 * 64'd4;
      3'd5:    t = TAU58 * 64'd5;
      3'd6:    t = TAU58 * 64'd6;
      default: t = TAU58 * 64'd7;
    endcase
    return t;
  endfunction

  // Inverse-factorial coefficients in Q.60
  function automatic logic signed [63:0] coef(input logic is_sin, input logic [2:0] idx);
    logic signed [63:0] c;
    if (is_sin) begin
      case (idx)
        3'd0:    c = 64'sd1152921504606846976;
        3'd1:    c = -64'sd192153584101141163;
        3'd2:    c = 64'sd9607679205057058;
        3'd3:    c = -64'sd228754266787073;
        3'd4:    c = 64'sd3177142594265;
        3'd5:    c = -64'sd28883114493;
        3'd6:    c = 64'sd185148170;
        default: c = -64'sd881658;
      endcase
    end else begin
      case (idx)
        3'd0:    c = 64'sd1152921504606846976;
        3'd1:    c = -64'sd576460752303423488;
        3'd2:    c = 64'sd48038396025285291;
        3'd3:    c = -64'sd1601279867509510;
        3'd4:    c = 64'sd28594283348384;
        3'd5:    c = -64'sd317714259426;
        3'd6:    c = 64'sd2406926208;
        default: c = -64'sd13224869;
      endcase
    end
    return c;
  endfunction

  // Term added after the product: none for the square and the final x multiply
  function automatic logic signed [63:0] mac_addend(input logic is_sin, input step_t step);
    logic signed [63:0] a;
    a = '0;
    if (step inside {[4'd1:4'd7]}) begin
      a = coef(is_sin, 3'(4'd7 - step));
    end
    return a;
  endfunction

endpackage

/* hdl/scp_reduce.sv */
// Range reduction modulo 2*pi and folding about pi and pi/2, seven elastic stages
module scp_reduce (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  input  logic signed [31:0]  in_angle,
  output logic                out_valid,
  input  logic                out_ready,
  output scp_pkg::side_t      out_side
);

  logic        v_r      [scp_pkg::RED_STAGES];
  logic        rdy      [scp_pkg::RED_STAGES];
  logic        sin_r    [scp_pkg::RED_STAGES];
  logic        sgn_in_r [4];

  logic [31:0] mag0_r, mag1_r, mag2_r;
  logic [2:0]  q1_r;
  logic [63:0] tsel2_r, rem3_r, rem4_r, rem5_r, x60_r;
  logic        neg4_r, neg5_r, neg6_r;

  logic [31:0] mag_nxt;
  logic [63:0] prod_nxt;
  logic [63:0] tq_nxt, tsel_nxt, rem3_nxt, rem4_nxt, rem5_nxt, rem6_nxt;
  logic        gt_nxt, neg5_nxt, neg6_nxt;

  always_comb begin
    rdy[scp_pkg::RED_STAGES-1] = !v_r[scp_pkg::RED_STAGES-1] || out_ready;
    for (int i = scp_pkg::RED_STAGES - 2; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[scp_pkg::RED_STAGES-1];

  always_comb begin
    mag_nxt  = in_angle[31] ? 32'(-in_angle) : 32'(in_angle);
    prod_nxt = mag0_r * scp_pkg::INV_TAU32;
    // correct a quotient estimate that overshoots
    tq_nxt   = scp_pkg::tau_mult(q1_r);
    gt_nxt   = (q1_r != 3'd0) && (tq_nxt > {mag1_r, 32'b0});
    tsel_nxt = gt_nxt ? scp_pkg::tau_mult(q1_r - 3'd1) : tq_nxt;
    rem3_nxt = {mag2_r, 32'b0} - tsel2_r;
    rem4_nxt = (rem3_r >= scp_pkg::TAU58) ? rem3_r - scp_pkg::TAU58 : rem3_r;
    rem5_nxt = rem4_r;
    neg5_nxt = neg4_r;
    if (rem4_r > scp_pkg::PI58) begin
      rem5_nxt = scp_pkg::TAU58 - rem4_r;
      neg5_nxt = neg4_r ^ sin_r[4];
    end
    rem6_nxt = rem5_r;
    neg6_nxt = neg5_r;
    if (rem5_r > scp_pkg::HALF58) begin
      rem6_nxt = scp_pkg::PI58 - rem5_r;
      neg6_nxt = neg5_r ^ !sin_r[5];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < scp_pkg::RED_STAGES; i++) begin
        v_r[i] <= 1'b0;
      end
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < scp_pkg::RED_STAGES; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      sin_r[0]    <= in_op;
      sgn_in_r[0] <= in_angle[31];
      mag0_r      <= mag_nxt;
    end
    for (int i = 1; i < scp_pkg::RED_STAGES; i++) begin
      if (rdy[i]) begin
        sin_r[i] <= sin_r[i-1];
      end
    end
    for (int i = 1; i < 4; i++) begin
      if (rdy[i]) begin
        sgn_in_r[i] <= sgn_in_r[i-1];
      end
    end
    if (rdy[1]) begin
      q1_r   <= prod_nxt[60:58];
      mag1_r <= mag0_r;
    end
    if (rdy[2]) begin
      tsel2_r <= tsel_nxt;
      mag2_r  <= mag1_r;
    end
    if (rdy[3]) begin
      rem3_r <= rem3_nxt;
    end
    if (rdy[4]) begin
      rem4_r <= rem4_nxt;
      neg4_r <= sin_r[3] && sgn_in_r[3];
    end
    if (rdy[5]) begin
      rem5_r <= rem5_nxt;
      neg5_r <= neg5_nxt;
    end
    if (rdy[6]) begin
      x60_r  <= {rem6_nxt[61:0], 2'b00};
      neg6_r <= neg6_nxt;
    end
  end

  always_comb begin
    out_side.is_sin = sin_r[scp_pkg::RED_STAGES-1];
    out_side.neg    = neg6_r;
    out_side.x60    = x60_r;
    out_side.y      = '0;
  end

endmodule

/* hdl/scp_mac.sv */
// Signed Q.60 multiply with half-away rounding and coefficient add, five elastic stages
module scp_mac (
  input  logic                clk,
  input  logic                rst_n,
  input  scp_pkg::step_t      step,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [63:0]  in_p,
  input  logic [63:0]         in_b,
  input  scp_pkg::side_t      in_side,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [63:0]  out_p,
  output scp_pkg::side_t      out_side
);

  logic           v_r    [scp_pkg::MAC_STAGES];
  logic           rdy    [scp_pkg::MAC_STAGES];
  logic           sgn_r  [scp_pkg::MAC_STAGES-1];
  scp_pkg::side_t side_r [scp_pkg::MAC_STAGES];

  logic [63:0]        mag0_r, b0_r;
  logic [63:0]        pp00_r, pp01_r, pp10_r, pp11_r;
  logic [64:0]        mid2_r;
  logic [127:0]       lo2_r;
  logic [63:0]        mag3_r;
  logic signed [63:0] p4_r;

  logic [63:0]        mag_nxt;
  logic [63:0]        pp00_nxt, pp01_nxt, pp10_nxt, pp11_nxt;
  logic [64:0]        mid_nxt;
  logic [127:0]       full_nxt;
  logic signed [63:0] term_nxt, p_nxt;

  always_comb begin
    rdy[scp_pkg::MAC_STAGES-1] = !v_r[scp_pkg::MAC_STAGES-1] || out_ready;
    for (int i = scp_pkg::MAC_STAGES - 2; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[scp_pkg::MAC_STAGES-1];
  assign out_p     = p4_r;
  assign out_side  = side_r[scp_pkg::MAC_STAGES-1];

  always_comb begin
    // multiply on the magnitude, reapply the sign afterwards
    mag_nxt  = in_p[63] ? 64'(-in_p) : 64'(in_p);
    pp00_nxt = mag0_r[31:0]  * b0_r[31:0];
    pp01_nxt = mag0_r[31:0]  * b0_r[63:32];
    pp10_nxt = mag0_r[63:32] * b0_r[31:0];
    pp11_nxt = mag0_r[63:32] * b0_r[63:32];
    mid_nxt  = {1'b0, pp01_r} + {1'b0, pp10_r};
    full_nxt = lo2_r + {31'b0, mid2_r, 32'b0} + scp_pkg::ROUND60;
    term_nxt = sgn_r[3] ? -signed'(mag3_r) : signed'(mag3_r);
    p_nxt    = scp_pkg::mac_addend(side_r[3].is_sin, step) + term_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < scp_pkg::MAC_STAGES; i++) begin
        v_r[i] <= 1'b0;
      end
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < scp_pkg::MAC_STAGES; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      mag0_r    <= mag_nxt;
      b0_r      <= in_b;
      sgn_r[0]  <= in_p[63];
      side_r[0] <= in_side;
    end
    for (int i = 1; i < scp_pkg::MAC_STAGES; i++) begin
      if (rdy[i]) begin
        side_r[i] <= side_r[i-1];
      end
    end
    for (int i = 1; i < scp_pkg::MAC_STAGES - 1; i++) begin
      if (rdy[i]) begin
        sgn_r[i] <= sgn_r[i-1];
      end
    end
    if (rdy[1]) begin
      pp00_r <= pp00_nxt;
      pp01_r <= pp01_nxt;
      pp10_r <= pp10_nxt;
      pp11_r <= pp11_nxt;
    end
    if (rdy[2]) begin
      mid2_r <= mid_nxt;
      lo2_r  <= {pp11_r, pp00_r};
    end
    if (rdy[3]) begin
      mag3_r <= full_nxt[123:60];
    end
    if (rdy[4]) begin
      p4_r <= p_nxt;
    end
  end

endmodule

/* hdl/sine_cosine_polynomial.sv */
// Sine / cosine polynomial evaluator, top level
//
//   channel  handshake             payload
//   input    in_valid / in_ready   in_op (1), in_angle (32, signed Q5.26)
//   result   out_valid / out_ready out_value (32, signed Q1.30)
//
// One transfer per cycle on each side while out_ready stays high.
// 54 register stages: 7 for reduction, nine 5-stage multiply-add units, 2 for output.
// Every stage holds its own item; a stall backs up stage by stage and empty stages keep filling.
// Reset clears the valid bits only; the data registers are not reset.
`include "sine_cosine_polynomial_assert.svh"

module sine_cosine_polynomial (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  input  logic signed [31:0]  in_angle,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_value
);

  logic               mv [scp_pkg::NUM_MAC+1];
  logic               mr [scp_pkg::NUM_MAC+1];
  scp_pkg::side_t     ms [scp_pkg::NUM_MAC+1];
  logic signed [63:0] mp [scp_pkg::NUM_MAC+1];

  assign mp[0] = '0;

  scp_reduce u_reduce (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .in_angle  (in_angle),
    .out_valid (mv[0]),
    .out_ready (mr[0]),
    .out_side  (ms[0])
  );

  // unit 0 squares x, units 1..7 run the Horner steps, the last one multiplies by x (by one for cosine)
  for (genvar k = 0; k < scp_pkg::NUM_MAC; k++) begin : g_mac
    logic signed [63:0] p_in;
    logic [63:0]        b_in;
    scp_pkg::side_t     s_in;

    always_comb begin
      s_in = ms[k];
      p_in = mp[k];
      b_in = ms[k].y;
      if (k == 0) begin
        p_in = signed'(ms[k].x60);
        b_in = ms[k].x60;
      end else if (k == 1) begin
        s_in.y = unsigned'(mp[k]);
        p_in   = scp_pkg::coef(ms[k].is_sin, 3'd7);
        b_in   = unsigned'(mp[k]);
      end else if (k == scp_pkg::NUM_MAC - 1) begin
        // cosine passes through a multiply by one
        b_in = ms[k].is_sin ? ms[k].x60 : scp_pkg::ONE60;
      end
    end

    scp_mac u_mac (
      .clk       (clk),
      .rst_n     (rst_n),
      .step      (scp_pkg::step_t'(k)),
      .in_valid  (mv[k]),
      .in_ready  (mr[k]),
      .in_p      (p_in),
      .in_b      (b_in),
      .in_side   (s_in),
      .out_valid (mv[k+1]),
      .out_ready (mr[k+1]),
      .out_p     (mp[k+1]),
      .out_side  (ms[k+1])
    );
  end

  logic               f1_v_r, out_valid_r;
  logic               f1_rdy, f2_rdy;
  logic [30:0]        res_r;
  logic               neg_r;
  logic signed [31:0] out_value_r;

  logic [63:0]        pm_nxt, sum_nxt;
  logic [33:0]        q_nxt;
  logic [30:0]        res_nxt;
  logic signed [31:0] value_nxt;

  assign f2_rdy               = !out_valid_r || out_ready;
  assign f1_rdy               = !f1_v_r || f2_rdy;
  assign mr[scp_pkg::NUM_MAC] = f1_rdy;
  assign out_valid            = out_valid_r;
  assign out_value            = out_value_r;

  always_comb begin
    // drop a negative sum, round to Q1.30 and clamp at one
    pm_nxt    = mp[scp_pkg::NUM_MAC][63] ? '0 : unsigned'(mp[scp_pkg::NUM_MAC]);
    sum_nxt   = pm_nxt + scp_pkg::ROUND30;
    q_nxt     = sum_nxt[63:30];
    res_nxt   = (q_nxt > 34'(scp_pkg::SAT30)) ? scp_pkg::SAT30 : q_nxt[30:0];
    value_nxt = neg_r ? -signed'({1'b0, res_r}) : signed'({1'b0, res_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (f1_rdy) begin
        f1_v_r <= mv[scp_pkg::NUM_MAC];
      end
      if (f2_rdy) begin
        out_valid_r <= f1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (f1_rdy) begin
      res_r <= res_nxt;
      neg_r <= ms[scp_pkg::NUM_MAC].neg ^ mp[scp_pkg::NUM_MAC][63];
    end
    if (f2_rdy) begin
      out_value_r <= value_nxt;
    end
  end

  logic out_in_range;

  assign out_in_range = (out_value >= -32'sd1073741824) && (out_value <= 32'sd1073741824);

  `SCP_ASSERT_IMPL(a_fold_range, mv[0], ms[0].x60 <= (scp_pkg::HALF58 << 2), "x above pi/2")
  `SCP_ASSERT_IMPL(a_square_sign, mv[1], !mp[1][63], "square of the angle is negative")
  `SCP_ASSERT_IMPL(a_out_range, out_valid, out_in_range, "result beyond one")
  `SCP_ASSERT_HOLD(a_stall_source, in_ready || (out_valid && !out_ready), "input stalled early")

endmodule

/* dv/tb_sine_cosine_polynomial.sv */
// Testbench for the sine / cosine polynomial evaluator: directed table, random angles, own predictor
`timescale 1ns / 1ps

module tb_sine_cosine_polynomial;

  typedef enum logic {FN_COS = 1'b0, FN_SIN = 1'b1} fn_t;

  typedef struct packed {
    fn_t         fn;
    logic [31:0] angle;
    logic        typed;
    logic [31:0] value;
  } vector_t;

  typedef struct packed {
    fn_t         fn;
    logic [31:0] angle;
    logic [31:0] value;
  } pending_t;

  localparam int NUM_VECTORS  = 25;
  localparam int ITEMS_PHASE  = 560;
  localparam int DRAIN_CYCLES = 64;
  localparam int LIMIT_CYCLES = 200000;

  // Angle constants in Q.58, reciprocal of a full turn in Q0.32
  localparam logic [63:0] PI_Q58      = 64'd905502432259640358;
  localparam logic [63:0] HALF_PI_Q58 = PI_Q58 >> 1;
  localparam logic [63:0] TURN_Q58    = PI_Q58 << 1;
  localparam logic [63:0] INV_TURN    = 64'd683565275;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  // round(2^60 / n!) for the even and odd series
  localparam logic signed [63:0] COS_TERMS [0:7] = '{
    64'sd1152921504606846976, -64'sd576460752303423488, 64'sd48038396025285291,
    -64'sd1601279867509510, 64'sd28594283348384, -64'sd317714259426,
    64'sd2406926208, -64'sd13224869
  };
  localparam logic signed [63:0] SIN_TERMS [0:7] = '{
    64'sd1152921504606846976, -64'sd192153584101141163, 64'sd9607679205057058,
    -64'sd228754266787073, 64'sd3177142594265, -64'sd28883114493,
    64'sd185148170, -64'sd881658
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_op = 1'b0;
  logic signed [31:0] in_angle = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_value;

  pending_t pending_q [$];
  pending_t oldest;
  vector_t  vectors [NUM_VECTORS];
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       n_errors = 0;
  int       n_sent = 0;
  int       n_checked = 0;

  sine_cosine_polynomial dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .in_angle  (in_angle),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #(LIMIT_CYCLES * 10);
    $display("timeout: %0d transfers in, %0d results checked", n_sent, n_checked);
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    n_errors++;
  endtask

  // (a * b) / 2^60, rounded half up
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b} + (128'd1 << 59);
    return prod[123:60];
  endfunction

  // Signed by unsigned Q.60 product, rounded on the magnitude
  function automatic logic signed [63:0] mul_q60_signed(input logic signed [63:0] p,
                                                        input logic [63:0] u);
    logic [63:0] mag;
    logic [63:0] prod;
    mag  = p[63] ? -p : p;
    prod = mul_q60(mag, u);
    return p[63] ? -prod : prod;
  endfunction

  function automatic logic [31:0] sincos_q30(input fn_t fn, input logic [31:0] angle);
    logic [63:0]        mag, turns, rem, x, sq, pos, res;
    logic signed [63:0] acc;
    logic               is_sin, flip;
    int                 i;
    is_sin = (fn == FN_SIN);
    mag    = angle[31] ? (64'd1 << 32) - {32'd0, angle} : {32'd0, angle};
    // estimate whole turns, then correct the estimate
    turns  = (mag * INV_TURN) >> 58;
    if (turns != 0 && turns * TURN_Q58 > (mag << 32)) turns = turns - 64'd1;
    rem = (mag << 32) - turns * TURN_Q58;
    if (rem >= TURN_Q58) rem = rem - TURN_Q58;
    flip = is_sin && angle[31];
    if (rem > PI_Q58) begin
      rem = TURN_Q58 - rem;
      if (is_sin) flip = !flip;
    end
    if (rem > HALF_PI_Q58) begin
      rem = PI_Q58 - rem;
      if (!is_sin) flip = !flip;
    end
    x   = rem << 2;
    sq  = mul_q60(x, x);
    acc = is_sin ? SIN_TERMS[7] : COS_TERMS[7];
    for (i = 6; i >= 0; i--) begin
      acc = (is_sin ? SIN_TERMS[i] : COS_TERMS[i]) + mul_q60_signed(acc, sq);
    end
    if (is_sin) acc = mul_q60_signed(acc, x);
    pos = acc[63] ? 64'd0 : acc;
    res = (pos + (64'd1 << 29)) >> 30;
    if (res > ONE_Q30) res = ONE_Q30;
    if (acc[63]) flip = !flip;
    return flip ? -res[31:0] : res[31:0];
  endfunction

  function automatic logic [31:0] pick_angle();
    int k;
    int a;
    case ($urandom_range(5))
      0, 1: a = $urandom();
      2: a = $urandom_range(421657429);
      3: begin
        // land close to a multiple of pi/2, either sign
        k = $urandom_range(20);
        a = $rtoi(k * 105414357.1535) + int'($urandom_range(128)) - 64;
        if ($urandom_range(1)) a = -a;
      end
      4: begin
        a = $urandom_range(4095);
        if ($urandom_range(1)) a = -a;
      end
      default: a = $urandom_range(1) ? 32'h7FFF_FF00 + $urandom_range(255)
                                     : 32'h8000_0000 + $urandom_range(255);
    endcase
    return a;
  endfunction

  // Call right after a rising edge; returns right after the edge that takes the transfer
  task automatic send_angle(input fn_t fn, input logic [31:0] angle, input logic typed,
                            input logic [31:0] typed_value);
    pending_t item;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= fn;
    in_angle <= angle;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    item.fn    = fn;
    item.angle = angle;
    item.value = typed ? typed_value : sincos_q30(fn, angle);
    pending_q.push_back(item);
    n_sent++;
  endtask

  task automatic drain_pending();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("value %h with nothing pending", out_value));
      end else begin
        oldest = pending_q.pop_front();
        n_checked++;
        if (out_value !== oldest.value) begin
          report_mismatch($sformatf("%s angle %h: value %h, want %h", oldest.fn.name(),
                                    oldest.angle, out_value, oldest.value));
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    vectors = '{
      '{FN_COS, 32'h0000_0000, 1'b1, 32'h4000_0000},
      '{FN_SIN, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{FN_SIN, 32'h0000_0001, 1'b1, 32'h0000_0010},
      '{FN_SIN, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFF0},
      '{FN_COS, 32'h0000_0001, 1'b0, 32'h0},
      '{FN_COS, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{FN_COS, 32'h7FFF_FFFF, 1'b0, 32'h0},
      '{FN_SIN, 32'h7FFF_FFFF, 1'b0, 32'h0},
      '{FN_COS, 32'h8000_0000, 1'b0, 32'h0},
      '{FN_SIN, 32'h8000_0000, 1'b0, 32'h0},
      '{FN_COS, 32'd105414357, 1'b0, 32'h0},
      '{FN_COS, 32'd105414358, 1'b0, 32'h0},
      '{FN_SIN, 32'd105414357, 1'b0, 32'h0},
      '{FN_SIN, 32'd105414358, 1'b0, 32'h0},
      '{FN_COS, 32'd210828714, 1'b0, 32'h0},
      '{FN_COS, 32'd210828715, 1'b0, 32'h0},
      '{FN_SIN, 32'd210828714, 1'b0, 32'h0},
      '{FN_SIN, 32'd210828715, 1'b0, 32'h0},
      '{FN_COS, 32'd316243071, 1'b0, 32'h0},
      '{FN_SIN, 32'd316243072, 1'b0, 32'h0},
      '{FN_COS, 32'd421657428, 1'b0, 32'h0},
      '{FN_COS, 32'd421657429, 1'b0, 32'h0},
      '{FN_SIN, 32'd421657428, 1'b0, 32'h0},
      '{FN_SIN, 32'd421657429, 1'b0, 32'h0},
      '{FN_SIN, -32'sd105414357, 1'b0, 32'h0}
    };
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 19;
    recv_idle_pct = 57;
    for (int v = 0; v < NUM_VECTORS; v++) begin
      send_angle(vectors[v].fn, vectors[v].angle, vectors[v].typed, vectors[v].value);
    end
    // hold off until the pipeline is empty
    drain_pending();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 57 : 0;
      recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 19 : 0;
      for (int n = 0; n < ITEMS_PHASE; n++) begin
        send_angle(fn_t'($urandom_range(1)), pick_angle(), 1'b0, 32'h0);
      end
      drain_pending();
    end

    // catch any stray result
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_q.size() != 0) report_mismatch($sformatf("%0d results never came",
                                                         pending_q.size()));

    $display("covered %0d angle transfers (%0d table rows), %0d results compared",
             n_sent, NUM_VECTORS, n_checked);
    $display("both functions, full-range and near-fold angles, three stall mixes");
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
